// ===== sv/sjsl_pkg.sv =====
`default_nettype none

package sjsl_pkg;

  // lexer phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE = 6'b000001,
    PH_STR  = 6'b000010,
    PH_ESC  = 6'b000100,
    PH_UESC = 6'b001000,
    PH_UBAD = 6'b010000,
    PH_UTF8 = 6'b100000
  } phase_t;

  typedef enum logic [3:0] {
    ERR_NONE         = 4'd0,
    ERR_EXPECTED_STR = 4'd1,
    ERR_CONTROL      = 4'd2,
    ERR_UTF8         = 4'd3,
    ERR_OPEN_ESC     = 4'd4,
    ERR_NONCANON_U   = 4'd5,
    ERR_BAD_HEX      = 4'd6,
    ERR_NONCTRL_U    = 4'd7,
    ERR_BAD_ESC      = 4'd8,
    ERR_UNTERMINATED = 4'd9
  } err_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       string_done;
    logic [3:0] error_code;
  } out_word_t;

  typedef struct packed {
    phase_t     phase;
    logic [1:0] utf8_remaining;
    logic [7:0] next_cont_min;
    logic [7:0] next_cont_max;
    logic [1:0] uescape_count;
    logic [3:0] high_nibble;
  } lex_state_t;

  // ascii codes
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_BSLASH  = 8'h5c;
  localparam logic [7:0] CH_SLASH   = 8'h2f;
  localparam logic [7:0] CH_LOWER_B = 8'h62;
  localparam logic [7:0] CH_LOWER_F = 8'h66;
  localparam logic [7:0] CH_LOWER_N = 8'h6e;
  localparam logic [7:0] CH_LOWER_R = 8'h72;
  localparam logic [7:0] CH_LOWER_T = 8'h74;
  localparam logic [7:0] CH_LOWER_U = 8'h75;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_F = 8'h46;

  localparam logic [7:0] CODE_BS = 8'h08;
  localparam logic [7:0] CODE_FF = 8'h0c;

  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  // utf-8 lead and continuation bounds
  localparam logic [7:0] CONT_MIN    = 8'h80;
  localparam logic [7:0] CONT_MAX    = 8'hbf;
  localparam logic [7:0] LEAD2_MIN   = 8'hc2;
  localparam logic [7:0] LEAD2_MAX   = 8'hdf;
  localparam logic [7:0] LEAD_E0     = 8'he0;
  localparam logic [7:0] LEAD_E1     = 8'he1;
  localparam logic [7:0] LEAD_EC     = 8'hec;
  localparam logic [7:0] LEAD_ED     = 8'hed;
  localparam logic [7:0] LEAD_EE     = 8'hee;
  localparam logic [7:0] LEAD_EF     = 8'hef;
  localparam logic [7:0] LEAD_F0     = 8'hf0;
  localparam logic [7:0] LEAD_F1     = 8'hf1;
  localparam logic [7:0] LEAD_F3     = 8'hf3;
  localparam logic [7:0] LEAD_F4     = 8'hf4;
  localparam logic [7:0] CONT_MIN_E0 = 8'ha0;
  localparam logic [7:0] CONT_MAX_ED = 8'h9f;
  localparam logic [7:0] CONT_MIN_F0 = 8'h90;
  localparam logic [7:0] CONT_MAX_F4 = 8'h8f;

  localparam lex_state_t STATE_IDLE = '{
    phase:          PH_IDLE,
    utf8_remaining: 2'd0,
    next_cont_min:  CONT_MIN,
    next_cont_max:  CONT_MAX,
    uescape_count:  2'd0,
    high_nibble:    4'd0
  };

endpackage

`default_nettype wire

// ===== sv/sjsl_if.sv =====
`default_nettype none

interface sjsl_if #(
  parameter type word_t = logic
);
  logic  valid;
  logic  ready;
  word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/sjsl_step.sv =====
`default_nettype none

// next-state and result logic for one word
module sjsl_step (
  input  wire sjsl_pkg::lex_state_t st,
  input  wire sjsl_pkg::in_word_t   word,
  output sjsl_pkg::lex_state_t      st_next,
  output sjsl_pkg::out_word_t       res
);

  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= sjsl_pkg::CH_ZERO && c <= sjsl_pkg::CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= sjsl_pkg::CH_LOWER_A && c <= sjsl_pkg::CH_LOWER_F) ||
                 (c >= sjsl_pkg::CH_UPPER_A && c <= sjsl_pkg::CH_UPPER_F)) begin
      r = {1'b1, 4'(c[3:0] + 4'd9)};
    end
    return r;
  endfunction

  logic [7:0]       b;
  logic [4:0]       hex;
  logic [7:0]       u_value;
  sjsl_pkg::err_t   err;
  logic             done;
  sjsl_pkg::lex_state_t nxt;

  assign b       = word.in_byte;
  assign hex     = hex_digit(b);
  assign u_value = {st.high_nibble, hex[3:0]};

  always_comb begin
    nxt          = st;
    err          = sjsl_pkg::ERR_NONE;
    done         = 1'b0;
    res.out_byte  = 8'd0;
    res.out_valid = 1'b0;

    if (word.end_of_input) begin
      unique case (st.phase)
        sjsl_pkg::PH_IDLE: err = sjsl_pkg::ERR_EXPECTED_STR;
        sjsl_pkg::PH_STR:  err = sjsl_pkg::ERR_UNTERMINATED;
        sjsl_pkg::PH_ESC:  err = sjsl_pkg::ERR_OPEN_ESC;
        sjsl_pkg::PH_UESC: err = sjsl_pkg::ERR_NONCANON_U;
        sjsl_pkg::PH_UBAD: err = sjsl_pkg::ERR_NONCANON_U;
        sjsl_pkg::PH_UTF8: err = sjsl_pkg::ERR_UTF8;
        default:           err = sjsl_pkg::ERR_UNTERMINATED;
      endcase
    end else begin
      unique case (st.phase)
        sjsl_pkg::PH_IDLE: begin
          if (b == sjsl_pkg::CH_SPACE || b == sjsl_pkg::CH_TAB ||
              b == sjsl_pkg::CH_LF || b == sjsl_pkg::CH_CR) begin
            nxt = st;
          end else if (b == sjsl_pkg::CH_QUOTE) begin
            nxt.phase = sjsl_pkg::PH_STR;
          end else begin
            err = sjsl_pkg::ERR_EXPECTED_STR;
          end
        end
        sjsl_pkg::PH_STR: begin
          priority if (b == sjsl_pkg::CH_QUOTE) begin
            done = 1'b1;
          end else if (b < sjsl_pkg::CTRL_LIMIT) begin
            err = sjsl_pkg::ERR_CONTROL;
          end else if (b >= sjsl_pkg::CONT_MIN) begin
            // utf-8 lead: sequence length and first continuation bounds
            res.out_byte      = b;
            res.out_valid     = 1'b1;
            nxt.phase         = sjsl_pkg::PH_UTF8;
            nxt.next_cont_min = sjsl_pkg::CONT_MIN;
            nxt.next_cont_max = sjsl_pkg::CONT_MAX;
            priority if (b >= sjsl_pkg::LEAD2_MIN && b <= sjsl_pkg::LEAD2_MAX) begin
              nxt.utf8_remaining = 2'd1;
            end else if (b == sjsl_pkg::LEAD_E0) begin
              nxt.utf8_remaining = 2'd2;
              nxt.next_cont_min  = sjsl_pkg::CONT_MIN_E0;
            end else if ((b >= sjsl_pkg::LEAD_E1 && b <= sjsl_pkg::LEAD_EC) ||
                         b == sjsl_pkg::LEAD_EE || b == sjsl_pkg::LEAD_EF) begin
              nxt.utf8_remaining = 2'd2;
            end else if (b == sjsl_pkg::LEAD_ED) begin
              nxt.utf8_remaining = 2'd2;
              nxt.next_cont_max  = sjsl_pkg::CONT_MAX_ED;
            end else if (b == sjsl_pkg::LEAD_F0) begin
              nxt.utf8_remaining = 2'd3;
              nxt.next_cont_min  = sjsl_pkg::CONT_MIN_F0;
            end else if (b >= sjsl_pkg::LEAD_F1 && b <= sjsl_pkg::LEAD_F3) begin
              nxt.utf8_remaining = 2'd3;
            end else if (b == sjsl_pkg::LEAD_F4) begin
              nxt.utf8_remaining = 2'd3;
              nxt.next_cont_max  = sjsl_pkg::CONT_MAX_F4;
            end else begin
              // no such lead: nothing is emitted
              res.out_byte  = 8'd0;
              res.out_valid = 1'b0;
              err           = sjsl_pkg::ERR_UTF8;
            end
          end else if (b == sjsl_pkg::CH_BSLASH) begin
            nxt.phase = sjsl_pkg::PH_ESC;
          end else begin
            res.out_byte  = b;
            res.out_valid = 1'b1;
          end
        end
        sjsl_pkg::PH_ESC: begin
          nxt.phase     = sjsl_pkg::PH_STR;
          res.out_valid = 1'b1;
          unique case (b)
            sjsl_pkg::CH_QUOTE:   res.out_byte = sjsl_pkg::CH_QUOTE;
            sjsl_pkg::CH_BSLASH:  res.out_byte = sjsl_pkg::CH_BSLASH;
            sjsl_pkg::CH_SLASH:   res.out_byte = sjsl_pkg::CH_SLASH;
            sjsl_pkg::CH_LOWER_B: res.out_byte = sjsl_pkg::CODE_BS;
            sjsl_pkg::CH_LOWER_F: res.out_byte = sjsl_pkg::CODE_FF;
            sjsl_pkg::CH_LOWER_N: res.out_byte = sjsl_pkg::CH_LF;
            sjsl_pkg::CH_LOWER_R: res.out_byte = sjsl_pkg::CH_CR;
            sjsl_pkg::CH_LOWER_T: res.out_byte = sjsl_pkg::CH_TAB;
            sjsl_pkg::CH_LOWER_U: begin
              res.out_valid     = 1'b0;
              nxt.phase         = sjsl_pkg::PH_UESC;
              nxt.uescape_count = 2'd0;
              nxt.high_nibble   = 4'd0;
            end
            default: begin
              res.out_valid = 1'b0;
              err           = sjsl_pkg::ERR_BAD_ESC;
            end
          endcase
        end
        sjsl_pkg::PH_UESC: begin
          priority if (st.uescape_count < 2'd2) begin
            if (b != sjsl_pkg::CH_ZERO) begin
              err = sjsl_pkg::ERR_NONCANON_U;
            end else begin
              nxt.uescape_count = st.uescape_count + 2'd1;
            end
          end else if (st.uescape_count == 2'd2) begin
            // a bad third digit is reported one character later
            if (!hex[4]) begin
              nxt.phase = sjsl_pkg::PH_UBAD;
            end else begin
              nxt.high_nibble   = hex[3:0];
              nxt.uescape_count = 2'd3;
            end
          end else begin
            if (!hex[4]) begin
              err = sjsl_pkg::ERR_BAD_HEX;
            end else if (u_value >= sjsl_pkg::CTRL_LIMIT) begin
              err = sjsl_pkg::ERR_NONCTRL_U;
            end else begin
              res.out_byte      = u_value;
              res.out_valid     = 1'b1;
              nxt.phase         = sjsl_pkg::PH_STR;
              nxt.uescape_count = 2'd0;
              nxt.high_nibble   = 4'd0;
            end
          end
        end
        sjsl_pkg::PH_UBAD: begin
          err = sjsl_pkg::ERR_BAD_HEX;
        end
        sjsl_pkg::PH_UTF8: begin
          if (b < st.next_cont_min || b > st.next_cont_max) begin
            err = sjsl_pkg::ERR_UTF8;
          end else begin
            res.out_byte      = b;
            res.out_valid     = 1'b1;
            nxt.next_cont_min = sjsl_pkg::CONT_MIN;
            nxt.next_cont_max = sjsl_pkg::CONT_MAX;
            if (st.utf8_remaining <= 2'd1) begin
              nxt.utf8_remaining = 2'd0;
              nxt.phase          = sjsl_pkg::PH_STR;
            end else begin
              nxt.utf8_remaining = st.utf8_remaining - 2'd1;
            end
          end
        end
        default: begin
          err = sjsl_pkg::ERR_EXPECTED_STR;
        end
      endcase
    end

    res.string_done = done;
    res.error_code  = err;
    st_next         = (done || err != sjsl_pkg::ERR_NONE) ? sjsl_pkg::STATE_IDLE : nxt;
  end

endmodule

`default_nettype wire

// ===== sv/strict_json_string_lexer.sv =====
`default_nettype none

// channel  modport  word        fields
// raw      sink     in_word_t   in_byte[7:0], end_of_input
// lexed    source   out_word_t  out_byte[7:0], out_valid, string_done, error_code[3:0]
//
// one result word per raw word, one word per cycle sustained while lexed is ready
// path: raw word -> input register -> result register
// the lexer state updates as a word moves from the input register into the result register
// rst (synchronous) returns to idle, awaiting the opening quote, and empties both registers
// a stall on lexed holds the result register; the input register still takes a word
// while it is empty, so raw backs up only when both registers are full
module strict_json_string_lexer (
  input wire clk,
  input wire rst,
  sjsl_if.sink   raw,
  sjsl_if.source lexed
);

  // input register
  logic               in_full;
  sjsl_pkg::in_word_t in_word;

  // result register
  logic                res_full;
  sjsl_pkg::out_word_t res_word;

  // lexer state
  sjsl_pkg::lex_state_t st;
  sjsl_pkg::lex_state_t st_next;
  sjsl_pkg::out_word_t  step_res;

  logic advance;

  // the input word moves on when the result register is free or being emptied
  assign advance   = in_full && (!res_full || lexed.ready);
  assign raw.ready = !in_full || advance;

  assign lexed.valid = res_full;
  assign lexed.data  = res_word;

  sjsl_step u_step (
    .st      (st),
    .word    (in_word),
    .st_next (st_next),
    .res     (step_res)
  );

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full  <= 1'b0;
      res_full <= 1'b0;
      st       <= sjsl_pkg::STATE_IDLE;
    end else begin
      if (raw.ready) begin
        in_full <= raw.valid;
      end
      if (advance) begin
        res_full <= 1'b1;
        st       <= st_next;
      end else if (lexed.ready) begin
        res_full <= 1'b0;
      end
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (raw.valid && raw.ready) begin
      in_word <= raw.data;
    end
    if (advance) begin
      res_word <= step_res;
    end
  end

  // a finished or failed string always leaves the lexer idle
  a_idle_after_end: assert property (@(posedge clk) disable iff (rst)
    advance && (step_res.string_done || step_res.error_code != sjsl_pkg::ERR_NONE)
    |=> st.phase == sjsl_pkg::PH_IDLE)
    else $error("lexer not idle after completion or error");

  // continuation bytes are only pending inside a utf-8 sequence
  a_utf8_count: assert property (@(posedge clk) disable iff (rst)
    st.phase == sjsl_pkg::PH_UTF8 || st.utf8_remaining == 2'd0)
    else $error("utf-8 count set outside a sequence");

  // a result word carries at most one of byte, completion and error
  a_result_exclusive: assert property (@(posedge clk) disable iff (rst)
    res_full && (res_word.string_done || res_word.error_code != sjsl_pkg::ERR_NONE)
    |-> !res_word.out_valid &&
        !(res_word.string_done && res_word.error_code != sjsl_pkg::ERR_NONE))
    else $error("result word mixes byte, completion or error");

  // a held input word is not overwritten
  a_input_hold: assert property (@(posedge clk) disable iff (rst)
    in_full && !advance |=> in_full && $stable(in_word))
    else $error("input register lost a word");

  // the state only moves when a word is passed on
  a_state_moves_on_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(st))
    else $error("lexer state changed without a word");

endmodule

`default_nettype wire
